### rtl/hlf_pkg.sv
`timescale 1ns / 1ps
package hlf_pkg;

    localparam int MaxStates = 4;
    localparam int IdxW = 2;
    localparam int CntW = 3;
    localparam int ValW = 40;
    localparam int SumW = 24;

    localparam logic signed [ValW-1:0] NegInf = {1'b1, {(ValW-1){1'b0}}};
    localparam logic signed [ValW-1:0] PosMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic [16:0] Log2e = 17'd94548;
    localparam logic [15:0] Ln2 = 16'd45426;

    typedef enum logic [1:0] {
        FUNC_WR_TRANS = 2'd0,
        FUNC_WR_INIT  = 2'd1,
        FUNC_EMIT     = 2'd2,
        FUNC_FINISH   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]             func;
        logic [IdxW-1:0]        row_index;
        logic [IdxW-1:0]        col_index;
        logic                   first_step;
        logic signed [ValW-1:0] value;
        logic signed [ValW-1:0] extra_term;
    } in_item_t;

    typedef struct packed {
        logic signed [ValW-1:0] result_value;
        logic                   status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TERM,
        ST_MAX,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_LOG1,
        ST_LOG2,
        ST_LOG3,
        ST_ADD_VAL,
        ST_ADD_EXTRA,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic            load_item;
        logic            do_write;
        logic            advance_col;
        logic            first_init;
        logic            term_ld;
        logic            max_clr;
        logic            max_acc;
        logic            sum_clr;
        logic            exp1;
        logic            exp3;
        logic            log1;
        logic            log2;
        logic            log3;
        logic            add_val;
        logic            add_extra;
        logic            store_cur;
        logic            set_reject;
        logic            set_zero;
        logic [IdxW-1:0] j;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0]      func;
        logic            first_step;
        logic            reject;
        logic            max_is_inf;
        logic            term_is_inf;
        logic [CntW-1:0] n;
    } dp_stat_t;

    localparam logic [16:0] Pow2Neg [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44345, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    localparam logic [16:0] Log2Mant [17] = '{
        17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
        17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    function automatic logic signed [ValW-1:0] add_sat(
        input logic signed [ValW-1:0] a,
        input logic signed [ValW-1:0] b
    );
        logic signed [ValW:0] s;
        logic signed [ValW-1:0] r;
        s = {a[ValW-1], a} + {b[ValW-1], b};
        if (a == NegInf || b == NegInf) r = NegInf;
        else if (s[ValW] != s[ValW-1]) r = s[ValW] ? NegInf : PosMax;
        else r = s[ValW-1:0];
        return r;
    endfunction

endpackage

### rtl/hlf_ctrl.sv
`timescale 1ns / 1ps
module hlf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    input  hlf_pkg::dp_stat_t stat,
    output hlf_pkg::dp_cmd_t  cmd
);

    hlf_pkg::state_t state_reg, state_next;
    logic [hlf_pkg::IdxW-1:0] j_reg, j_next;
    logic                     fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hlf_pkg::ST_IDLE;
            j_reg     <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            fin_reg   <= fin_next;
        end
    end

    logic last_j;
    assign last_j = ({1'b0, j_reg} == stat.n - hlf_pkg::CntW'(1));

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.j      = j_reg;
        busy       = (state_reg != hlf_pkg::ST_IDLE);
        done       = 1'b0;
        unique case (state_reg)
            hlf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = hlf_pkg::ST_DECODE;
                end
            end
            hlf_pkg::ST_DECODE:
            begin
                j_next = '0;
                cmd.max_clr = 1'b1;
                cmd.sum_clr = 1'b1;
                if (stat.func == hlf_pkg::FUNC_FINISH)
                begin
                    fin_next   = 1'b1;
                    state_next = hlf_pkg::ST_TERM;
                end
                else if (stat.reject)
                begin
                    cmd.set_reject = 1'b1;
                    state_next     = hlf_pkg::ST_DONE;
                end
                else if (stat.func == hlf_pkg::FUNC_EMIT)
                begin
                    fin_next        = 1'b0;
                    cmd.advance_col = 1'b1;
                    if (stat.first_step)
                    begin
                        cmd.first_init = 1'b1;
                        state_next     = hlf_pkg::ST_ADD_VAL;
                    end
                    else
                        state_next = hlf_pkg::ST_TERM;
                end
                else
                begin
                    cmd.do_write = 1'b1;
                    cmd.set_zero = 1'b1;
                    state_next   = hlf_pkg::ST_DONE;
                end
            end
            hlf_pkg::ST_TERM:
            begin
                cmd.term_ld = 1'b1;
                state_next  = hlf_pkg::ST_MAX;
            end
            hlf_pkg::ST_MAX:
            begin
                cmd.max_acc = 1'b1;
                if (last_j)
                begin
                    j_next     = '0;
                    state_next = hlf_pkg::ST_EXP1;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = hlf_pkg::ST_TERM;
                end
            end
            hlf_pkg::ST_EXP1:
            begin
                if (stat.max_is_inf)
                begin
                    state_next = fin_reg ? hlf_pkg::ST_DONE : hlf_pkg::ST_ADD_VAL;
                end
                else
                begin
                    cmd.term_ld = 1'b1;
                    state_next  = hlf_pkg::ST_EXP2;
                end
            end
            hlf_pkg::ST_EXP2:
            begin
                cmd.exp1   = 1'b1;
                state_next = hlf_pkg::ST_EXP3;
            end
            hlf_pkg::ST_EXP3:
            begin
                if (!stat.term_is_inf) cmd.exp3 = 1'b1;
                if (last_j)
                    state_next = hlf_pkg::ST_LOG1;
                else
                begin
                    j_next      = j_reg + 1'b1;
                    cmd.term_ld = 1'b0;
                    state_next  = hlf_pkg::ST_EXP1;
                end
            end
            hlf_pkg::ST_LOG1:
            begin
                cmd.log1   = 1'b1;
                state_next = hlf_pkg::ST_LOG2;
            end
            hlf_pkg::ST_LOG2:
            begin
                cmd.log2   = 1'b1;
                state_next = hlf_pkg::ST_LOG3;
            end
            hlf_pkg::ST_LOG3:
            begin
                cmd.log3   = 1'b1;
                state_next = fin_reg ? hlf_pkg::ST_DONE : hlf_pkg::ST_ADD_VAL;
            end
            hlf_pkg::ST_ADD_VAL:
            begin
                cmd.add_val = 1'b1;
                state_next  = hlf_pkg::ST_ADD_EXTRA;
            end
            hlf_pkg::ST_ADD_EXTRA:
            begin
                cmd.add_extra = 1'b1;
                state_next    = hlf_pkg::ST_DONE;
            end
            hlf_pkg::ST_DONE:
            begin
                if (!fin_reg && stat.func == hlf_pkg::FUNC_EMIT && !stat.reject)
                    cmd.store_cur = 1'b1;
                fin_next   = 1'b0;
                done       = 1'b1;
                state_next = hlf_pkg::ST_IDLE;
            end
            default: state_next = hlf_pkg::ST_IDLE;
        endcase
    end

endmodule

### rtl/hlf_dp.sv
`timescale 1ns / 1ps
module hlf_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hlf_pkg::in_item_t       item,
    input  logic                    cfg_valid,
    input  logic [hlf_pkg::CntW-1:0] cfg_data,
    input  hlf_pkg::dp_cmd_t        cmd,
    output hlf_pkg::dp_stat_t       stat,
    output hlf_pkg::out_item_t      result
);

    localparam int V = hlf_pkg::ValW;
    localparam int M = hlf_pkg::MaxStates;

    hlf_pkg::in_item_t          item_reg;
    logic [hlf_pkg::CntW-1:0]   nst_reg;
    logic signed [V-1:0]        trans_reg [M*M];
    logic signed [V-1:0]        init_reg [M];
    logic signed [V-1:0]        prev_reg [M];
    logic signed [V-1:0]        cur_reg [M];
    logic signed [V-1:0]        term_reg, max_reg, acc_reg;
    logic [hlf_pkg::SumW-1:0]   sum_reg;
    logic [33:0]                y_reg;
    logic                       inf_reg;
    logic [4:0]                 p_reg;
    logic [16:0]                mant_reg;
    logic [21:0]                lg_reg;
    logic                       status_reg;

    logic [hlf_pkg::CntW-1:0] n;
    assign n = (nst_reg == '0) ? hlf_pkg::CntW'(1) :
               (nst_reg > hlf_pkg::CntW'(M)) ? hlf_pkg::CntW'(M) : nst_reg;

    logic reject;
    assign reject = ({1'b0, item_reg.row_index} >= n) ||
                    (item_reg.func == hlf_pkg::FUNC_WR_TRANS &&
                     {1'b0, item_reg.col_index} >= n);

    assign stat.func        = item_reg.func;
    assign stat.first_step  = item_reg.first_step;
    assign stat.reject      = reject;
    assign stat.max_is_inf  = (max_reg == hlf_pkg::NegInf);
    assign stat.term_is_inf = inf_reg;
    assign stat.n           = n;

    logic signed [V-1:0] term_src;
    always_comb
    begin
        if (item_reg.func == hlf_pkg::FUNC_FINISH) term_src = cur_reg[cmd.j];
        else term_src = hlf_pkg::add_sat(prev_reg[cmd.j],
                                         trans_reg[{cmd.j, item_reg.row_index}]);
    end

    // exp: x = c - a, y = x*log2e >> 16
    logic signed [V:0] dif;
    logic [V-1:0]      x;
    logic [15:0]       f;
    logic [4:0]        idx;
    logic [16:0]       hi, lo, mi;
    logic [29:0]       prod_e;
    always_comb
    begin
        dif    = {max_reg[V-1], max_reg} - {term_reg[V-1], term_reg};
        x      = dif[V-1:0];
        f      = y_reg[15:0];
        idx    = {1'b0, f[15:12]};
        hi     = hlf_pkg::Pow2Neg[idx];
        lo     = hlf_pkg::Pow2Neg[idx + 5'd1];
        prod_e = (hi - lo) * f[11:0];
        mi     = hi - 17'(prod_e >> 12);
    end

    // log: msb search over the sum
    logic [4:0]  pos;
    logic [15:0] fr;
    logic [4:0]  li;
    logic [16:0] la, lb;
    logic [29:0] prod_l;
    always_comb
    begin
        pos = 5'd16;
        for (int k = 17; k < hlf_pkg::SumW; k++)
            if (sum_reg[k]) pos = 5'(k);
        fr     = mant_reg[15:0];
        li     = {1'b0, fr[15:12]};
        la     = hlf_pkg::Log2Mant[li];
        lb     = hlf_pkg::Log2Mant[li + 5'd1];
        prod_l = (lb - la) * fr[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nst_reg <= hlf_pkg::CntW'(M);
            for (int i = 0; i < M; i++)
            begin
                prev_reg[i] <= hlf_pkg::NegInf;
                cur_reg[i]  <= hlf_pkg::NegInf;
            end
        end
        else
        begin
            if (cfg_valid) nst_reg <= cfg_data;
            if (cmd.advance_col && item_reg.row_index == '0)
            begin
                for (int i = 0; i < M; i++)
                begin
                    if (!item_reg.first_step) prev_reg[i] <= cur_reg[i];
                    cur_reg[i] <= hlf_pkg::NegInf;
                end
            end
            if (cmd.store_cur) cur_reg[item_reg.row_index] <= acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item) item_reg <= item;
        if (cmd.do_write)
        begin
            if (item_reg.func == hlf_pkg::FUNC_WR_TRANS)
                trans_reg[{item_reg.row_index, item_reg.col_index}] <= item_reg.value;
            else
                init_reg[item_reg.row_index] <= item_reg.value;
        end
        if (cmd.max_clr) max_reg <= hlf_pkg::NegInf;
        else if (cmd.max_acc && term_reg > max_reg) max_reg <= term_reg;
        if (cmd.sum_clr) sum_reg <= '0;
        else if (cmd.exp3)
            sum_reg <= sum_reg + hlf_pkg::SumW'(
                ((y_reg[33:16] >= 18'd17) ? 17'd0 : mi) >> y_reg[20:16]);
        if (cmd.term_ld)
        begin
            term_reg <= term_src;
        end
        if (cmd.exp1)
        begin
            inf_reg <= (term_reg == hlf_pkg::NegInf);
            if (x >= V'(32) << 16) y_reg <= {5'd17, 29'd0};
            else y_reg <= 34'((39'(x[21:0]) * 39'(hlf_pkg::Log2e)) >> 16);
        end
        if (cmd.log1)
        begin
            p_reg    <= pos;
            mant_reg <= 17'(sum_reg >> (pos - 5'd16));
        end
        if (cmd.log2)
            lg_reg <= {p_reg - 5'd16, 16'd0} + 22'(la) + 22'(prod_l >> 12);
        // one write to the accumulator per cycle, rejects and writes first
        if (cmd.set_reject || cmd.set_zero) acc_reg <= '0;
        else if (cmd.first_init) acc_reg <= init_reg[item_reg.row_index];
        else if (cmd.max_clr) acc_reg <= hlf_pkg::NegInf;
        else if (cmd.log3)
            acc_reg <= hlf_pkg::add_sat(max_reg,
                V'((38'(lg_reg) * hlf_pkg::Ln2 + 38'd32768) >> 16));
        else if (cmd.add_val) acc_reg <= hlf_pkg::add_sat(acc_reg, item_reg.value);
        else if (cmd.add_extra) acc_reg <= hlf_pkg::add_sat(acc_reg, item_reg.extra_term);
        if (cmd.set_reject) status_reg <= 1'b1;
        else if (cmd.max_clr) status_reg <= 1'b0;
    end

    assign result.result_value = acc_reg;
    assign result.status       = status_reg;

endmodule

### rtl/hmm_log_forward_likelihood.sv
`timescale 1ns / 1ps
// log-domain hmm forward recursion, q24.16 values, most negative is minus infinity
// command channel: item taken at a clock edge with start high and busy low
// func 0/1 load transition / initial tables, 2 one emission for a state, 3 finish
// each item gives exactly one result beat, marked by done for one cycle
// result_value carries the new forward value or the total log-likelihood
// status flags a state index at or beyond num_states, where num_states 0 counts as 1
// config channel: cfg_valid/cfg_ready write num_states, always ready, use while idle
// writes and rejects go from decode to done, a first-step emission adds value
// then extra term, later emission and finish walk the previous column serially:
// term and max for each state, then exp for each state, then log; emission then adds
// value and extra term, and a column that is all minus infinity skips exp and log
// the exp table unit and the three-step log unit are shared and used in turn
// one item at a time; the next start is taken the cycle after done
// reset clears the columns to minus infinity and sets num_states to 4
// the tables stay undefined until written
// the receiver cannot stall: the result beat is gone after its one cycle
module hmm_log_forward_likelihood (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hlf_pkg::in_item_t  item,
    output logic               done,
    output hlf_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data
);

    hlf_pkg::dp_cmd_t  cmd;
    hlf_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    hlf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    hlf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule
